// ===== sv/psieve_pkg.sv =====
package psieve_pkg;

    localparam int NUM_CELLS_DEF  = 64;
    localparam int VALUE_BITS_DEF = 16;
    localparam int PORT_BITS      = 16;

    localparam logic OP_TEST  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic dbit;
        logic hit;
    } tok_t;

endpackage

// ===== sv/pipelined_prime_sieve_top.sv =====
// Prime sieve over a chain of NUM_CELLS cells, one stored prime per cell.
// A test beat is taken only when the block is idle; its value is sent MSB
// first, one bit a cycle, down the chain, and each cell keeps the running
// remainder of the value modulo its own prime. A test beat passes through
// a feed phase, in which its bits enter the chain, a drain phase, which
// ends when the last bit reaches the end of the chain, and an emit phase.
// Clear beats and candidates below 2 give no result. A survivor is stored
// in the next free cell; with every cell used it is still emitted, with
// table_full set. The result sits in an output register until taken; a
// new beat may be accepted while it waits.
module pipelined_prime_sieve_top #(
    parameter int NUM_CELLS  = psieve_pkg::NUM_CELLS_DEF,
    parameter int VALUE_BITS = psieve_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [psieve_pkg::PORT_BITS-1:0] candidate,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [psieve_pkg::PORT_BITS-1:0] prime_value,
    output logic                             table_full
);

    localparam int CNT_W = $clog2(NUM_CELLS + 1);
    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam int PB    = psieve_pkg::PORT_BITS;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(NUM_CELLS);
    localparam logic [BIT_W-1:0] LAST_BIT   = BIT_W'(VALUE_BITS - 1);

    psieve_pkg::state_t    state_reg;
    psieve_pkg::state_t    state_next;
    logic [CNT_W-1:0]      used_reg;
    logic [CNT_W-1:0]      used_next;
    logic [BIT_W-1:0]      bit_reg;
    logic [BIT_W-1:0]      bit_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  hit_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PB-1:0]         out_value_reg;
    logic                  out_full_reg;
    logic [VALUE_BITS-1:0] cand_val;
    logic [PB-1:0]         value_port;
    logic                  load_value;
    logic                  load_out;
    logic                  store;
    logic                  full;
    logic                  out_free;
    psieve_pkg::tok_t      inject;
    psieve_pkg::tok_t      chain [NUM_CELLS+1];

    generate
        if (VALUE_BITS <= PB)
        begin : g_narrow
            assign cand_val   = candidate[VALUE_BITS-1:0];
            assign value_port = PB'(value_reg);
        end
        else
        begin : g_wide
            assign cand_val   = VALUE_BITS'(candidate);
            assign value_port = value_reg[PB-1:0];
        end
    endgenerate

    assign full     = (used_reg == FULL_COUNT);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        bit_next       = bit_reg;
        in_stall       = 1'b1;
        load_value     = 1'b0;
        load_out       = 1'b0;
        store          = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        inject         = '0;
        case (state_reg)
            psieve_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (op == psieve_pkg::OP_CLEAR)
                    begin
                        used_next = '0;
                    end
                    else if (cand_val >= VALUE_BITS'(2))
                    begin
                        load_value = 1'b1;
                        bit_next   = '0;
                        state_next = psieve_pkg::ST_FEED;
                    end
                end
            end
            psieve_pkg::ST_FEED:
            begin
                inject.valid = 1'b1;
                inject.first = (bit_reg == '0);
                inject.last  = (bit_reg == LAST_BIT);
                inject.dbit  = value_reg[LAST_BIT - bit_reg];
                bit_next     = bit_reg + BIT_W'(1);
                if (bit_reg == LAST_BIT)
                begin
                    state_next = psieve_pkg::ST_DRAIN;
                end
            end
            psieve_pkg::ST_DRAIN:
            begin
                if (chain[NUM_CELLS].valid && chain[NUM_CELLS].last)
                begin
                    state_next = psieve_pkg::ST_EMIT;
                end
            end
            psieve_pkg::ST_EMIT:
            begin
                if (hit_reg)
                begin
                    state_next = psieve_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    store          = !full;
                    if (!full)
                    begin
                        used_next = used_reg + CNT_W'(1);
                    end
                    state_next = psieve_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psieve_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psieve_pkg::ST_IDLE;
            used_reg      <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_value)
        begin
            value_reg <= cand_val;
        end
        if (state_reg == psieve_pkg::ST_DRAIN)
        begin
            hit_reg <= chain[NUM_CELLS].hit;
        end
        if (load_out)
        begin
            out_value_reg <= value_port;
            out_full_reg  <= full;
        end
    end

    assign chain[0] = inject;

    genvar k;
    generate
        for (k = 0; k < NUM_CELLS; k++)
        begin : g_cell
            localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(k);
            psieve_cell #(
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .tok_in (chain[k]),
                .tok_out(chain[k+1]),
                .active (used_reg > CELL_IDX),
                .wr_en  (store && (used_reg == CELL_IDX)),
                .wr_data(value_reg)
            );
        end
    endgenerate

    assign out_valid   = out_valid_reg;
    assign prime_value = out_value_reg;
    assign table_full  = out_full_reg;

endmodule

// ===== sv/psieve_cell.sv =====
module psieve_cell #(
    parameter int VALUE_BITS = psieve_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psieve_pkg::tok_t      tok_in,
    output psieve_pkg::tok_t      tok_out,
    input  logic                  active,
    input  logic                  wr_en,
    input  logic [VALUE_BITS-1:0] wr_data
);

    logic [VALUE_BITS-1:0] prime_reg;
    logic [VALUE_BITS-1:0] res_reg;
    logic [VALUE_BITS-1:0] res_next;
    logic [VALUE_BITS-1:0] res_base;
    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   divisor;
    logic [VALUE_BITS:0]   reduced;
    psieve_pkg::tok_t      tok_reg;
    psieve_pkg::tok_t      tok_next;

    always_comb
    begin
        res_base = tok_in.first ? '0 : res_reg;
        shifted  = {res_base, tok_in.dbit};
        divisor  = {1'b0, prime_reg};
        reduced  = (shifted >= divisor) ? (shifted - divisor) : shifted;
        res_next = reduced[VALUE_BITS-1:0];
        tok_next = tok_in;
        tok_next.hit = tok_in.hit
                       | (tok_in.valid & tok_in.last & active & (res_next == '0));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prime_reg <= wr_data;
        end
        if (tok_in.valid)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== sim/pipelined_prime_sieve_top_test.sv =====
`timescale 1ns / 100ps

module pipelined_prime_sieve_top_test;

    localparam int CELLS       = psieve_pkg::NUM_CELLS_DEF;
    localparam int PORT_BITS   = psieve_pkg::PORT_BITS;
    localparam int BEAT_TARGET = 1800;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic [PORT_BITS-1:0] value;
        logic                 full;
    } prime_rec_t;

    typedef struct {
        logic                 op;
        logic [PORT_BITS-1:0] cand;
        bit                   typed;
        logic [PORT_BITS-1:0] value;
        logic                 full;
    } sieve_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 op = psieve_pkg::OP_TEST;
    logic [PORT_BITS-1:0] candidate = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PORT_BITS-1:0] prime_value;
    logic                 table_full;

    logic [PORT_BITS-1:0] stored_primes [CELLS];
    int                   primes_held = 0;
    prime_rec_t           pending_primes [$];

    int  errors = 0;
    int  beats_counted = 0;
    int  clears_sent = 0;
    int  primes_checked = 0;
    int  full_flags = 0;
    int  in_idle_pct = 0;
    int  out_idle_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;

    sieve_row_t directed_rows [] = '{
        '{psieve_pkg::OP_CLEAR, 16'd0,     1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd0,     1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd1,     1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'hFFFF,  1'b1, 16'hFFFF,  1'b0},
        '{psieve_pkg::OP_TEST,  16'hFFFF,  1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_CLEAR, 16'h1234,  1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd2,     1'b1, 16'd2,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd3,     1'b1, 16'd3,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd4,     1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd5,     1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd9,     1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd3,     1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'hFFFF,  1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd65521, 1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'h8000,  1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd1,     1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_CLEAR, 16'hFFFF,  1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'h8000,  1'b1, 16'h8000,  1'b0},
        '{psieve_pkg::OP_TEST,  16'd0,     1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd2,     1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_TEST,  16'd7,     1'b0, 16'd0,     1'b0},
        '{psieve_pkg::OP_CLEAR, 16'd0,     1'b0, 16'd0,     1'b0}
    };

    pipelined_prime_sieve_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .candidate   (candidate),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .prime_value (prime_value),
        .table_full  (table_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit sieve_predict(input logic o, input logic [PORT_BITS-1:0] c,
                                         output prime_rec_t rec);
        rec.value = c;
        rec.full  = 1'b0;
        if (o == psieve_pkg::OP_CLEAR)
        begin
            primes_held = 0;
            return 1'b0;
        end
        if (c < 2)
            return 1'b0;
        for (int k = 0; k < primes_held; k++)
        begin
            if (stored_primes[k] != 0 && (c % stored_primes[k]) == 0)
                return 1'b0;
        end
        if (primes_held >= CELLS)
            rec.full = 1'b1;
        else
        begin
            stored_primes[primes_held] = c;
            primes_held++;
        end
        return 1'b1;
    endfunction

    task automatic send_beat(input logic o, input logic [PORT_BITS-1:0] c,
                             input bit typed = 1'b0,
                             input logic [PORT_BITS-1:0] tval = '0,
                             input logic tfull = 1'b0);
        prime_rec_t rec;
        bit         has_result;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        candidate <= c;
        do
            @(posedge clk);
        while (in_stall);
        has_result = sieve_predict(o, c, rec);
        if (typed)
        begin
            rec.value  = tval;
            rec.full   = tfull;
            has_result = 1'b1;
        end
        if (has_result)
            pending_primes.push_back(rec);
        if (o == psieve_pkg::OP_CLEAR)
            clears_sent++;
        if (o == psieve_pkg::OP_CLEAR || c >= 2)
            beats_counted++;
        @(negedge clk);
    endtask

    function automatic logic [PORT_BITS-1:0] noise_value();
        case ($urandom_range(3))
            0: return PORT_BITS'($urandom);
            1: return PORT_BITS'($urandom_range(1));
            2: return 16'hFFFF - PORT_BITS'($urandom_range(15));
            default: return PORT_BITS'($urandom_range(500, 2));
        endcase
    endfunction

    task automatic random_sequence(input bit force_long);
        int pick;
        int last;
        int step;
        int len;
        int start;
        pick = force_long ? 0 : $urandom_range(99);
        if (pick < 70)
        begin
            // ascending run from 2, the long ones spill past the table size
            if (force_long || $urandom_range(99) < 25)
                last = $urandom_range(420, 312);
            else
                last = $urandom_range(120, 3);
            send_beat(psieve_pkg::OP_CLEAR, noise_value());
            for (int v = 2; v <= last; v++)
                send_beat(psieve_pkg::OP_TEST, PORT_BITS'(v));
        end
        else if (pick < 85)
        begin
            start = $urandom_range(2000, 2);
            step  = $urandom_range(7, 1);
            len   = $urandom_range(40, 5);
            send_beat(psieve_pkg::OP_CLEAR, noise_value());
            for (int n = 0; n < len; n++)
                send_beat(psieve_pkg::OP_TEST, PORT_BITS'(start + n * step));
        end
        else
        begin
            len = $urandom_range(20, 1);
            for (int n = 0; n < len; n++)
                send_beat(($urandom_range(9) == 0) ? psieve_pkg::OP_CLEAR
                                                   : psieve_pkg::OP_TEST,
                          noise_value());
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge clk)
    begin : take_result
        prime_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_primes.size() == 0)
            begin
                $error("unexpected beat: prime_value %0d table_full %0d",
                       prime_value, table_full);
                errors++;
            end
            else
            begin
                want = pending_primes.pop_front();
                primes_checked++;
                if (table_full)
                    full_flags++;
                if (prime_value !== want.value)
                begin
                    $error("prime_value: expected %0d, got %0d", want.value, prime_value);
                    errors++;
                end
                if (table_full !== want.full)
                begin
                    $error("table_full: expected %0d, got %0d", want.full, table_full);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        in_idle_pct  = 10;
        out_idle_pct = 79;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].op, directed_rows[i].cand, directed_rows[i].typed,
                      directed_rows[i].value, directed_rows[i].full);

        random_sequence(1'b1);
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                in_idle_pct  = 79;
                out_idle_pct = 10;
            end
            else if (ph == 2)
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
                // hold the output off while the sender keeps pushing
                in_valid <= 1'b0;
                @(posedge clk);
                hold_req = 1'b1;
                @(negedge clk);
            end
            while (beats_counted < (ph + 1) * BEAT_TARGET / 3)
                random_sequence(1'b0);
        end
        in_valid <= 1'b0;

        wait (pending_primes.size() == 0);
        repeat (200) @(posedge clk);

        $display("Sent %0d beats including %0d clears; checked %0d primes, %0d flagged full.",
                 beats_counted, clears_sent, primes_checked, full_flags);
        $display("Runs covered empty, partly filled and overflowing tables under stalls.");
        if (errors == 0 && pending_primes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/psieve_pkg.sv
sv/psieve_cell.sv
sv/pipelined_prime_sieve_top.sv
sim/pipelined_prime_sieve_top_test.sv
